[design/psbm_pkg.sv]
// ----------------------------------------------------------------------------
// psbm_pkg
// shared types, constants and the cosine table builder of the beep mixer
// ----------------------------------------------------------------------------
package psbm_pkg;

	localparam int DIV_W     = 34;  // dividend width of the reciprocal divider
	localparam int REC_W     = 40;  // reciprocal width, holds 2^52 over the lowest rate
	localparam int HALF_W    = 20;  // reciprocal half taken per multiplier pass
	localparam int RES_W     = DIV_W + REC_W - HALF_W;  // product already shifted by HALF_W
	localparam int PHASE_W   = 24;
	localparam int ENV_W     = 16;
	localparam int SAMPLE_W  = 16;
	localparam longint HALF_PI_Q30 = 64'sd1686629713;

	typedef struct packed {
		logic             start;
		logic [DIV_W-1:0] dividend;
		logic [REC_W-1:0] recip;
	} div_req_t;

	typedef struct packed {
		logic             busy;
		logic [RES_W-1:0] quotient;
	} div_rsp_t;

	// saturate a 17-bit signed value to q1.15
	function automatic logic signed [SAMPLE_W-1:0] sat17(input logic signed [SAMPLE_W:0] v);
		logic signed [SAMPLE_W-1:0] r;
		if (v > 17'sd32767) begin
			r = 16'sh7FFF;
		end else if (v < -17'sd32768) begin
			r = 16'sh8000;
		end else begin
			r = v[SAMPLE_W-1:0];
		end
		return r;
	endfunction

	// q30 to q15, round half away from zero, +1.0 saturates
	function automatic logic signed [SAMPLE_W-1:0] q30_to_q15(input longint v);
		longint mag;
		longint r;
		mag = (v < 0) ? -v : v;
		r = (mag + (64'sd1 <<< 14)) >>> 15;
		if (r > 32767) begin
			r = 32767;
		end
		return SAMPLE_W'((v < 0) ? -r : r);
	endfunction

	// long division of non-negative values, only ever evaluated at elaboration
	function automatic longint div_pos(input longint num, input longint den);
		longint q;
		longint rem;
		q   = 0;
		rem = 0;
		for (int i = 62; i >= 0; i--) begin
			rem = (rem <<< 1) | ((num >>> i) & 64'sd1);
			if (rem >= den) begin
				rem = rem - den;
				q   = q | (64'sd1 <<< i);
			end
		end
		return q;
	endfunction

	// one cosine table entry, taylor series over the quarter wave
	function automatic logic signed [SAMPLE_W-1:0] cos_entry(input int k, input int bits);
		int     quad;
		longint r;
		longint th;
		longint x2;
		longint ct;
		longint st;
		longint c;
		longint s;
		longint dc;
		longint ds;
		logic signed [SAMPLE_W-1:0] res;
		quad = (k >> (bits - 2)) & 3;
		r    = longint'(k & ((1 << (bits - 2)) - 1));
		th   = (r * HALF_PI_Q30) >>> (bits - 2);
		x2   = (th * th) >>> 30;
		ct   = 64'sd1 <<< 30;
		st   = th;
		c    = ct;
		s    = st;
		for (int n = 1; n <= 8; n++) begin
			dc = longint'((2 * n - 1) * (2 * n));
			ds = longint'((2 * n) * (2 * n + 1));
			ct = div_pos((ct * x2) >>> 30, dc);
			st = div_pos((st * x2) >>> 30, ds);
			if ((n & 1) != 0) begin
				c = c - ct;
				s = s - st;
			end else begin
				c = c + ct;
				s = s + st;
			end
		end
		case (quad)
			0:       res = q30_to_q15(c);
			1:       res = q30_to_q15(-s);
			2:       res = q30_to_q15(-c);
			default: res = q30_to_q15(s);
		endcase
		return res;
	endfunction

endpackage

[design/psbm_div.sv]
// ----------------------------------------------------------------------------
// psbm_div
// division by a constant through its reciprocal, two multiplier passes
// ----------------------------------------------------------------------------
module psbm_div (
	input  logic                clk,
	input  logic                arst_n,
	input  psbm_pkg::div_req_t  req,
	output psbm_pkg::div_rsp_t  rsp
);

	localparam int PROD_W = psbm_pkg::DIV_W + psbm_pkg::HALF_W;

	logic                           busy_q;
	logic                           hi_q;
	logic [psbm_pkg::DIV_W-1:0]     dvd_q;
	logic [psbm_pkg::REC_W-1:0]     rec_q;
	logic [PROD_W-1:0]              lo_q;
	logic [psbm_pkg::RES_W-1:0]     res_q;
	logic [psbm_pkg::HALF_W-1:0]    mul_b;
	logic [PROD_W-1:0]              mul_p;

	// low half of the reciprocal first, then the high half
	assign mul_b = hi_q ? rec_q[psbm_pkg::REC_W-1:psbm_pkg::HALF_W]
	                    : rec_q[psbm_pkg::HALF_W-1:0];
	assign mul_p = dvd_q * mul_b;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			hi_q   <= 1'b0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			hi_q   <= 1'b0;
		end else if (busy_q) begin
			if (hi_q) begin
				busy_q <= 1'b0;
				hi_q   <= 1'b0;
			end else begin
				hi_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			dvd_q <= req.dividend;
			rec_q <= req.recip;
		end else if (busy_q) begin
			if (hi_q) begin
				res_q <= psbm_pkg::RES_W'(mul_p)
				       + psbm_pkg::RES_W'(lo_q[PROD_W-1:psbm_pkg::HALF_W]);
			end else begin
				lo_q <= mul_p;
			end
		end
	end

	assign rsp.busy     = busy_q;
	assign rsp.quotient = res_q;

	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> !req.start) else $error("divider restarted while busy");
	a_busy_len: assert property (@(posedge clk) disable iff (!arst_n)
		req.start |=> busy_q) else $error("divider did not start");
	a_two_pass: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy_q) |-> $past(hi_q)) else $error("divider stopped early");

endmodule

[design/psbm_cos_rom.sv]
// ----------------------------------------------------------------------------
// psbm_cos_rom
// cosine table built at elaboration, registered read
// ----------------------------------------------------------------------------
module psbm_cos_rom #(
	parameter int TABLE_BITS = 10
) (
	input  logic                                 clk,
	input  logic [TABLE_BITS-1:0]                addr,
	output logic signed [psbm_pkg::SAMPLE_W-1:0] data
);

	localparam int SIZE = 1 << TABLE_BITS;

	logic signed [psbm_pkg::SAMPLE_W-1:0] rom [SIZE];

	for (genvar k = 0; k < SIZE; k++) begin : g_rom
		localparam logic signed [psbm_pkg::SAMPLE_W-1:0] VAL =
			psbm_pkg::cos_entry(k, TABLE_BITS);
		assign rom[k] = VAL;
	end

	always_ff @(posedge clk) begin
		data <= rom[addr];
	end

endmodule

[design/polyphonic_sine_beep_mixer.sv]
// ----------------------------------------------------------------------------
// polyphonic_sine_beep_mixer
// bank of sine voices with linear envelopes, voice stealing and stereo mix
// ----------------------------------------------------------------------------
// channel  dir  signals                         content
// s_*      in   tvalid tready tdata[71:0] tuser  trigger or tick item
// m_*      out  tvalid tready tdata[31:0]        stereo sample, one per tick
// cfg_*    in   wr_en wr_data[15:0]              envelope_step register
//
// after the accept, a tick walks every voice: a sounding voice goes through
// the envelope step and the cos, left gain and right gain multiplies, a
// silent voice through the envelope step alone; two reciprocal divisions
// and the output load follow; a trigger walks every voice in the scan, and
// the phase step reciprocal division runs alongside the scan
// s_tready is high only while the sequencer is idle; a finished sample waits in
// the output register and the next item is taken meanwhile; a new sample stalls
// in the last step until the output register is free
// reset clears the voice active flags and the sequencer, no clearing pass
// ----------------------------------------------------------------------------
module polyphonic_sine_beep_mixer #(
	parameter int VOICES          = 16,
	parameter int SAMPLE_RATE     = 48000,
	parameter int SINE_TABLE_BITS = 10
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [71:0] s_tdata,   // freq_hz, duration_samples, beep_gain, beep_pan, zero pad
	input  logic        s_tuser,   // cmd
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // left_sample, right_sample
	input  logic        cfg_wr_en,
	input  logic [15:0] cfg_wr_data
);

	localparam int VW    = $clog2(VOICES);
	localparam int ACC_W = 50 + $clog2(VOICES) + 1;
	localparam int PW    = psbm_pkg::PHASE_W;
	localparam int EW    = psbm_pkg::ENV_W;
	localparam int SW    = psbm_pkg::SAMPLE_W;
	localparam int RW    = psbm_pkg::RES_W;

	// phase step = freq * STEP_INT + (freq * STEP_FRAC + rate/2) / rate
	localparam int     HALF_RATE  = SAMPLE_RATE / 2;
	localparam int     STEP_INT   = (1 << PW) / SAMPLE_RATE;
	localparam int     STEP_FRAC  = (1 << PW) % SAMPLE_RATE;
	localparam int     STEP_SHIFT = 52;
	localparam longint REC_STEP   = ((64'sd1 <<< STEP_SHIFT) + SAMPLE_RATE - 1) / SAMPLE_RATE;
	localparam int     STEP_SEL   = STEP_SHIFT - psbm_pkg::HALF_W;
	// mix division by VOICES, exact for dividends below 2^21
	localparam int     MIX_SHIFT  = 27;
	localparam longint REC_MIX    = ((64'sd1 <<< MIX_SHIFT) + VOICES - 1) / VOICES;
	localparam int     MIX_SEL    = MIX_SHIFT - psbm_pkg::HALF_W;

	typedef enum logic [3:0] {
		S_IDLE, S_SCAN, S_TWAIT, S_ENV, S_MUL1, S_MULL, S_MULR,
		S_DL_GO, S_DL_WAIT, S_DR_GO, S_DR_WAIT, S_OUT
	} state_t;

	state_t state_q;

	// configuration
	logic [EW-1:0] env_step_q;

	// voice storage
	logic                 active_q   [VOICES];
	logic [20:0]          elapsed_q  [VOICES];
	logic [19:0]          length_q   [VOICES];
	logic [PW-1:0]        phase_q    [VOICES];
	logic [PW-1:0]        pstep_q    [VOICES];
	logic [EW-1:0]        env_q      [VOICES];
	logic signed [SW-1:0] gain_l_q   [VOICES];
	logic signed [SW-1:0] gain_r_q   [VOICES];

	// sequencer registers
	logic [VW-1:0]        vidx_q;
	logic                 found_q;
	logic [VW-1:0]        free_q;
	logic [VW-1:0]        best_idx_q;
	logic [20:0]          best_q;
	logic [14:0]          t_freq_q;
	logic [19:0]          t_len_q;
	logic signed [SW-1:0] t_gain_q;
	logic signed [SW-1:0] t_pan_q;
	logic signed [32:0]   base_q;
	logic signed [ACC_W-1:0] accl_q;
	logic signed [ACC_W-1:0] accr_q;
	logic signed [SW-1:0] mix_l_q;
	logic signed [SW-1:0] mix_r_q;
	logic signed [SW-1:0] left_q;
	logic signed [SW-1:0] right_q;
	logic                 out_valid_q;

	// shared units
	psbm_pkg::div_req_t div_req;
	psbm_pkg::div_rsp_t div_rsp;
	logic signed [SW-1:0] cos_rd;
	logic signed [32:0]   mul_a;
	logic signed [16:0]   mul_b;
	logic signed [49:0]   mul_p;

	logic                 in_acc;
	logic                 last_voice;
	logic [EW:0]          env_sum;
	logic [EW-1:0]        env_new;
	logic                 rising;
	logic [VW-1:0]        sel_voice;
	logic                 sel_free;
	logic [ACC_W-1:0]     mag_l;
	logic [ACC_W-1:0]     mag_r;
	logic [RW-MIX_SEL-1:0] mix_q;
	logic signed [SW-1:0] mix_res;
	logic                 mix_neg;
	logic [27:0]          step_sum;
	logic                 wr_trig;
	logic                 out_load;

	assign in_acc     = s_tvalid && s_tready;
	assign s_tready   = (state_q == S_IDLE);
	assign last_voice = (vidx_q == VW'(VOICES - 1));

	// envelope step for the voice in hand
	assign rising  = elapsed_q[vidx_q] < {1'b0, length_q[vidx_q]};
	assign env_sum = {1'b0, env_q[vidx_q]} + {1'b0, env_step_q};
	always_comb begin
		if (rising) begin
			env_new = env_sum[EW] ? {EW{1'b1}} : env_sum[EW-1:0];
		end else if (env_q[vidx_q] > env_step_q) begin
			env_new = env_q[vidx_q] - env_step_q;
		end else begin
			env_new = '0;
		end
	end

	// the one multiplier: cos * envelope, then base * left gain, base * right gain
	always_comb begin
		unique case (state_q)
			S_MULL: begin
				mul_a = base_q;
				mul_b = {gain_l_q[vidx_q][SW-1], gain_l_q[vidx_q]};
			end
			S_MULR: begin
				mul_a = base_q;
				mul_b = {gain_r_q[vidx_q][SW-1], gain_r_q[vidx_q]};
			end
			default: begin
				mul_a = {{17{cos_rd[SW-1]}}, cos_rd};
				mul_b = {1'b0, env_q[vidx_q]};
			end
		endcase
	end
	assign mul_p = mul_a * mul_b;

	psbm_cos_rom #(
		.TABLE_BITS(SINE_TABLE_BITS)
	) u_rom (
		.clk (clk),
		.addr(phase_q[vidx_q][PW-1 -: SINE_TABLE_BITS]),
		.data(cos_rd)
	);

	// magnitudes of the sums; the divider takes them shifted down by 2^31
	assign mag_l = accl_q[ACC_W-1] ? ACC_W'(-accl_q) : ACC_W'(accl_q);
	assign mag_r = accr_q[ACC_W-1] ? ACC_W'(-accr_q) : ACC_W'(accr_q);

	always_comb begin
		div_req.start    = 1'b0;
		div_req.dividend = '0;
		div_req.recip    = psbm_pkg::REC_W'(REC_MIX);
		if (in_acc && s_tuser) begin
			// fractional part of the phase step, rounded half up
			div_req.start    = 1'b1;
			div_req.dividend = psbm_pkg::DIV_W'(s_tdata[14:0]) * psbm_pkg::DIV_W'(STEP_FRAC)
			                 + psbm_pkg::DIV_W'(HALF_RATE);
			div_req.recip    = psbm_pkg::REC_W'(REC_STEP);
		end else if (state_q == S_DL_GO) begin
			div_req.start    = 1'b1;
			div_req.dividend = psbm_pkg::DIV_W'(mag_l[ACC_W-1:31]);
		end else if (state_q == S_DR_GO) begin
			div_req.start    = 1'b1;
			div_req.dividend = psbm_pkg::DIV_W'(mag_r[ACC_W-1:31]);
		end
	end

	psbm_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (div_req),
		.rsp   (div_rsp)
	);

	// whole and fractional parts of the phase step, wrapped to the accumulator
	assign step_sum = 28'(t_freq_q) * 28'(STEP_INT)
	                + 28'(div_rsp.quotient[RW-1:STEP_SEL]);

	// saturate the quotient and put the sign back
	assign mix_q   = div_rsp.quotient[RW-1:MIX_SEL];
	assign mix_neg = (state_q == S_DL_WAIT) ? accl_q[ACC_W-1] : accr_q[ACC_W-1];
	always_comb begin
		if (mix_q >= (RW-MIX_SEL)'(32768)) begin
			mix_res = mix_neg ? 16'sh8000 : 16'sh7FFF;
		end else if (mix_neg) begin
			mix_res = SW'(-$signed({1'b0, mix_q[SW-2:0]}));
		end else begin
			mix_res = $signed({1'b0, mix_q[SW-2:0]});
		end
	end

	assign sel_voice = found_q ? free_q : best_idx_q;
	assign sel_free  = !active_q[vidx_q] && !found_q;
	assign wr_trig   = (state_q == S_TWAIT) && !div_rsp.busy;
	assign out_load  = (state_q == S_OUT) && (!out_valid_q || m_tready);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			env_step_q  <= 16'd3277;
			vidx_q      <= '0;
			found_q     <= 1'b0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < VOICES; i++) begin
				active_q[i] <= 1'b0;
			end
		end else begin
			if (cfg_wr_en) begin
				env_step_q <= cfg_wr_data;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && m_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					vidx_q  <= '0;
					found_q <= 1'b0;
					if (in_acc) begin
						state_q <= s_tuser ? S_SCAN : S_ENV;
					end
				end
				S_SCAN: begin
					// first free voice, else the one that has run longest
					if (sel_free) begin
						found_q <= 1'b1;
					end
					if (last_voice) begin
						state_q <= S_TWAIT;
					end else begin
						vidx_q <= vidx_q + 1'b1;
					end
				end
				S_TWAIT: begin
					if (wr_trig) begin
						active_q[sel_voice] <= 1'b1;
						state_q             <= S_IDLE;
					end
				end
				S_ENV: begin
					if (active_q[vidx_q] && env_new == '0) begin
						active_q[vidx_q] <= 1'b0;
					end
					if (active_q[vidx_q] && env_new != '0) begin
						state_q <= S_MUL1;
					end else if (last_voice) begin
						state_q <= S_DL_GO;
					end else begin
						vidx_q <= vidx_q + 1'b1;
					end
				end
				S_MUL1: state_q <= S_MULL;
				S_MULL: state_q <= S_MULR;
				S_MULR: begin
					if (last_voice) begin
						state_q <= S_DL_GO;
					end else begin
						vidx_q  <= vidx_q + 1'b1;
						state_q <= S_ENV;
					end
				end
				S_DL_GO:   state_q <= S_DL_WAIT;
				S_DL_WAIT: begin
					if (!div_rsp.busy) begin
						state_q <= S_DR_GO;
					end
				end
				S_DR_GO:   state_q <= S_DR_WAIT;
				S_DR_WAIT: begin
					if (!div_rsp.busy) begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					// wait for room in the output register
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (in_acc) begin
			t_freq_q <= s_tdata[14:0];
			t_len_q  <= s_tdata[34:15];
			t_gain_q <= s_tdata[50:35];
			t_pan_q  <= s_tdata[66:51];
			accl_q   <= '0;
			accr_q   <= '0;
		end
		if (state_q == S_SCAN) begin
			if (sel_free) begin
				free_q <= vidx_q;
			end
			if (vidx_q == '0 || elapsed_q[vidx_q] > best_q) begin
				best_q     <= elapsed_q[vidx_q];
				best_idx_q <= vidx_q;
			end
		end
		if (wr_trig) begin
			gain_l_q[sel_voice]  <= psbm_pkg::sat17({t_gain_q[SW-1], t_gain_q}
			                                      - {t_pan_q[SW-1], t_pan_q});
			gain_r_q[sel_voice]  <= psbm_pkg::sat17({t_gain_q[SW-1], t_gain_q}
			                                      + {t_pan_q[SW-1], t_pan_q});
			elapsed_q[sel_voice] <= '0;
			env_q[sel_voice]     <= '0;
			phase_q[sel_voice]   <= '0;
			length_q[sel_voice]  <= t_len_q;
			pstep_q[sel_voice]   <= step_sum[PW-1:0];
		end
		if (state_q == S_ENV && active_q[vidx_q]) begin
			env_q[vidx_q] <= env_new;
		end
		if (state_q == S_MUL1) begin
			base_q <= mul_p[32:0];
		end
		if (state_q == S_MULL) begin
			accl_q <= accl_q + ACC_W'(mul_p);
		end
		if (state_q == S_MULR) begin
			accr_q <= accr_q + ACC_W'(mul_p);
			if (elapsed_q[vidx_q] != {21{1'b1}}) begin
				elapsed_q[vidx_q] <= elapsed_q[vidx_q] + 1'b1;
			end
			phase_q[vidx_q] <= phase_q[vidx_q] + pstep_q[vidx_q];
		end
		// finished halves wait here so a pending sample is left untouched
		if (state_q == S_DL_WAIT && !div_rsp.busy) begin
			mix_l_q <= mix_res;
		end
		if (state_q == S_DR_WAIT && !div_rsp.busy) begin
			mix_r_q <= mix_res;
		end
		if (out_load) begin
			left_q  <= mix_l_q;
			right_q <= mix_r_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {right_q, left_q};

	a_out_from_seq: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == S_OUT)
		else $error("sample shown without a finished mix");
	a_trig_marks: assert property (@(posedge clk) disable iff (!arst_n)
		wr_trig |=> active_q[$past(sel_voice)])
		else $error("triggered voice not active");
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !m_tready) |=> out_valid_q)
		else $error("pending sample lost");
	a_idle_div: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> !div_rsp.busy)
		else $error("divider busy while idle");

endmodule
